// ----- design/npcs_pkg.sv -----
// ---------------------------------------------------------------------------
// npcs_pkg: shared types and constants for the nearest palette colour search
// Palette geometry, command encoding and stream widths used by all modules.
// ---------------------------------------------------------------------------
`default_nettype none

package npcs_pkg;

	// palette geometry: four entries per row, one row read per cycle
	localparam int PAL_ENTRIES = 256;
	localparam int LANES       = 4;
	localparam int LANE_W      = 2;
	localparam int ROWS        = (PAL_ENTRIES + LANES - 1) / LANES;
	localparam int ROW_W       = (ROWS > 1) ? $clog2(ROWS) : 1;
	localparam int SLOT_W      = ROW_W + LANE_W;
	localparam int SLOTS       = ROWS * LANES;

	// field widths
	localparam int IDX_W  = 8;
	localparam int COMP_W = 8;
	localparam int RGB_W  = 3 * COMP_W;
	localparam int DIST_W = 18;

	// stream widths
	localparam int S_TDATA_W = 40;
	localparam int S_TUSER_W = 2;
	localparam int M_TDATA_W = 8;

	// special source indices of the select map
	localparam logic [IDX_W-1:0]  SHADOW_SRC = 8'd168;
	localparam logic [IDX_W-1:0]  MOUSE_SRC  = 8'd255;
	localparam logic [COMP_W-1:0] COMP_MAX   = 8'd255;

	// divide by three through a reciprocal, exact for sums below 2048
	localparam logic [9:0] THIRD_RECIP = 10'd683;
	localparam int         THIRD_SHIFT = 11;

	// command queue
	localparam int CMDQ_DEPTH = 2;
	localparam int CMDQ_PTR_W = (CMDQ_DEPTH > 1) ? $clog2(CMDQ_DEPTH) : 1;
	localparam int CMDQ_CNT_W = $clog2(CMDQ_DEPTH + 1);

	typedef enum logic [1:0] {
		KIND_WRITE  = 2'd0,
		KIND_MATCH  = 2'd1,
		KIND_SELECT = 2'd2,
		KIND_TRANS  = 2'd3
	} kind_t;

	typedef enum logic [2:0] {
		OP_WRITE  = 3'd0,
		OP_MATCH  = 3'd1,
		OP_WHITE  = 3'd2,
		OP_AVG    = 3'd3,
		OP_BRIGHT = 3'd4
	} op_t;

	typedef struct packed {
		logic [COMP_W-1:0] red;
		logic [COMP_W-1:0] green;
		logic [COMP_W-1:0] blue;
	} colour_t;

	typedef struct packed {
		op_t              op;
		logic [IDX_W-1:0] src_index;
		logic [IDX_W-1:0] dst_index;
		colour_t          colour;
	} cmd_t;

endpackage

`default_nettype wire

// ----- design/npcs_front.sv -----
// ---------------------------------------------------------------------------
// npcs_front: input side of the nearest palette colour search
// Takes stream items, classifies them into commands and feeds the queue.
// ---------------------------------------------------------------------------
`default_nettype none

module npcs_front (
	input  wire logic                           s_tvalid,
	output logic                                s_tready,
	// src_index, dst_index, red, green, blue
	input  wire logic [npcs_pkg::S_TDATA_W-1:0] s_tdata,
	// kind
	input  wire logic [npcs_pkg::S_TUSER_W-1:0] s_tuser,
	input  wire logic                           q_full,
	output logic                                q_push,
	output npcs_pkg::cmd_t                      q_cmd
);

	npcs_pkg::kind_t kind;
	logic            keep;

	always_comb begin
		kind                 = npcs_pkg::kind_t'(s_tuser);
		q_cmd.src_index      = s_tdata[7:0];
		q_cmd.dst_index      = s_tdata[15:8];
		q_cmd.colour.red     = s_tdata[23:16];
		q_cmd.colour.green   = s_tdata[31:24];
		q_cmd.colour.blue    = s_tdata[39:32];
		keep                 = 1'b1;
		unique case (kind)
			npcs_pkg::KIND_WRITE: begin
				q_cmd.op = npcs_pkg::OP_WRITE;
				// writes beyond the palette are dropped here
				keep = ({1'b0, s_tdata[7:0]} < 9'(npcs_pkg::PAL_ENTRIES));
			end
			npcs_pkg::KIND_MATCH: begin
				q_cmd.op = npcs_pkg::OP_MATCH;
			end
			npcs_pkg::KIND_SELECT: begin
				if (s_tdata[7:0] == npcs_pkg::SHADOW_SRC) begin
					q_cmd.op = npcs_pkg::OP_WHITE;
				end else if (s_tdata[7:0] == npcs_pkg::MOUSE_SRC) begin
					q_cmd.op = npcs_pkg::OP_BRIGHT;
				end else begin
					q_cmd.op = npcs_pkg::OP_AVG;
				end
			end
			npcs_pkg::KIND_TRANS: begin
				q_cmd.op = npcs_pkg::OP_AVG;
			end
			default: begin
				q_cmd.op = npcs_pkg::OP_AVG;
			end
		endcase
	end

	assign s_tready = !q_full;
	assign q_push   = s_tvalid && !q_full && keep;

endmodule

`default_nettype wire

// ----- design/npcs_cmd_fifo.sv -----
// ---------------------------------------------------------------------------
// npcs_cmd_fifo: command queue between front and back
// Short register queue so that either side can stall on its own.
// ---------------------------------------------------------------------------
`default_nettype none

module npcs_cmd_fifo (
	input  wire logic           clk,
	input  wire logic           arst_n,
	input  wire logic           push,
	input  npcs_pkg::cmd_t      push_cmd,
	output logic                full,
	input  wire logic           pop,
	output logic                head_valid,
	output npcs_pkg::cmd_t      head_cmd
);

	npcs_pkg::cmd_t                  slot_q [npcs_pkg::CMDQ_DEPTH];
	logic [npcs_pkg::CMDQ_PTR_W-1:0] wr_ptr_q;
	logic [npcs_pkg::CMDQ_PTR_W-1:0] rd_ptr_q;
	logic [npcs_pkg::CMDQ_CNT_W-1:0] cnt_q;
	logic                            do_push;
	logic                            do_pop;

	assign full       = (cnt_q == npcs_pkg::CMDQ_CNT_W'(npcs_pkg::CMDQ_DEPTH));
	assign head_valid = (cnt_q != '0);
	assign head_cmd   = slot_q[rd_ptr_q];
	assign do_push    = push && !full;
	assign do_pop     = pop && head_valid;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (do_push) begin
				if (wr_ptr_q == npcs_pkg::CMDQ_PTR_W'(npcs_pkg::CMDQ_DEPTH - 1)) begin
					wr_ptr_q <= '0;
				end else begin
					wr_ptr_q <= wr_ptr_q + 1'b1;
				end
			end
			if (do_pop) begin
				if (rd_ptr_q == npcs_pkg::CMDQ_PTR_W'(npcs_pkg::CMDQ_DEPTH - 1)) begin
					rd_ptr_q <= '0;
				end else begin
					rd_ptr_q <= rd_ptr_q + 1'b1;
				end
			end
			if (do_push && !do_pop) begin
				cnt_q <= cnt_q + 1'b1;
			end else if (do_pop && !do_push) begin
				cnt_q <= cnt_q - 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (do_push) begin
			slot_q[wr_ptr_q] <= push_cmd;
		end
	end

endmodule

`default_nettype wire

// ----- design/npcs_back.sv -----
// ---------------------------------------------------------------------------
// npcs_back: palette store and search engine
// Executes commands: palette writes, target colour build and four-lane scan.
// ---------------------------------------------------------------------------
`default_nettype none

module npcs_back (
	input  wire logic                           clk,
	input  wire logic                           arst_n,
	input  wire logic                           cmd_valid,
	input  npcs_pkg::cmd_t                      cmd,
	output logic                                cmd_pop,
	output logic                                m_tvalid,
	input  wire logic                           m_tready,
	output logic [npcs_pkg::M_TDATA_W-1:0]      m_tdata
);

	typedef enum logic [4:0] {
		ST_IDLE  = 5'b00001,
		ST_SRC   = 5'b00010,
		ST_DST   = 5'b00100,
		ST_SCAN  = 5'b01000,
		ST_DRAIN = 5'b10000
	} state_t;

	localparam int L = npcs_pkg::LANES;

	function automatic logic [15:0] sq_diff(input logic [7:0] a, input logic [7:0] b);
		logic [7:0] d;
		d = (a > b) ? (a - b) : (b - a);
		return 16'(d) * 16'(d);
	endfunction

	function automatic logic [7:0] brighten(input logic [7:0] s, input logic [7:0] d);
		logic [10:0] x;
		logic [20:0] p;
		x = {3'b000, s} + {1'b0, d, 2'b00};
		p = 21'(x) * 21'(npcs_pkg::THIRD_RECIP);
		return (p[20:npcs_pkg::THIRD_SHIFT] > 10'd255) ? npcs_pkg::COMP_MAX :
			p[npcs_pkg::THIRD_SHIFT+7:npcs_pkg::THIRD_SHIFT];
	endfunction

	function automatic logic [7:0] avg(input logic [7:0] s, input logic [7:0] d);
		logic [8:0] sum;
		sum = {1'b0, s} + {1'b0, d};
		return sum[8:1];
	endfunction

	state_t st_q, st_d;

	// palette memory: one bank per lane, one row of four entries per address
	logic [npcs_pkg::RGB_W-1:0]  bank_q [L][npcs_pkg::ROWS];
	logic [npcs_pkg::SLOTS-1:0]  vld_q;

	npcs_pkg::op_t               op_q;
	logic [npcs_pkg::IDX_W-1:0]  src_q;
	logic [npcs_pkg::IDX_W-1:0]  dst_q;
	npcs_pkg::colour_t           s_ent_q;
	npcs_pkg::colour_t           tgt_q;
	npcs_pkg::colour_t           tgt_d;
	npcs_pkg::colour_t           sel_ent;
	logic [npcs_pkg::ROW_W-1:0]  row_q;

	logic                        pal_we;
	logic [npcs_pkg::ROW_W-1:0]  raddr;
	logic                        start_scan;
	logic                        pipe_empty;
	logic                        load_out;
	logic                        last_row;
	logic [npcs_pkg::IDX_W-1:0]  sel_idx;
	logic [npcs_pkg::LANE_W-1:0] sel_lane;
	logic                        sel_in_range;

	// stage 1: row read
	logic                        v_s1;
	logic [npcs_pkg::ROW_W-1:0]  row_s1;
	logic [npcs_pkg::RGB_W-1:0]  data_s1 [L];
	logic [L-1:0]                vld_s1;

	// stage 2: lane distances
	logic                        v_s2;
	logic [npcs_pkg::ROW_W-1:0]  row_s2;
	logic [npcs_pkg::DIST_W-1:0] dist_s2 [L];
	logic [L-1:0]                en_s2;
	logic [npcs_pkg::DIST_W-1:0] dist_d  [L];
	logic [L-1:0]                en_d;

	// stage 3: pair winners
	logic                        v_s3;
	logic [npcs_pkg::DIST_W-1:0] pd_s3   [2];
	logic [npcs_pkg::SLOT_W-1:0] pidx_s3 [2];
	logic [1:0]                  pen_s3;
	logic [npcs_pkg::DIST_W-1:0] pd_d    [2];
	logic [npcs_pkg::SLOT_W-1:0] pidx_d  [2];
	logic [1:0]                  pen_d;

	// running best
	logic [npcs_pkg::DIST_W-1:0] best_d_q;
	logic [npcs_pkg::SLOT_W-1:0] lead_slot_q;
	logic                        best_en_q;
	logic [npcs_pkg::DIST_W-1:0] fin_d;
	logic [npcs_pkg::SLOT_W-1:0] fin_idx;
	logic                        fin_en;
	logic                        best_upd;

	logic                        m_tvalid_q;
	logic [npcs_pkg::M_TDATA_W-1:0] m_tdata_q;

	// ---------------- control ----------------
	always_comb begin
		st_d       = st_q;
		cmd_pop    = 1'b0;
		start_scan = 1'b0;
		last_row   = (row_q == npcs_pkg::ROW_W'(npcs_pkg::ROWS - 1));
		pipe_empty = !v_s1 && !v_s2 && !v_s3;
		load_out   = 1'b0;
		raddr      = row_q;
		unique case (st_q)
			ST_IDLE: begin
				raddr = cmd.src_index[npcs_pkg::SLOT_W-1:npcs_pkg::LANE_W];
				if (cmd_valid) begin
					cmd_pop = 1'b1;
					priority case (cmd.op)
						npcs_pkg::OP_WRITE: st_d = ST_IDLE;
						npcs_pkg::OP_AVG, npcs_pkg::OP_BRIGHT: st_d = ST_SRC;
						default: begin
							st_d       = ST_SCAN;
							start_scan = 1'b1;
						end
					endcase
				end
			end
			ST_SRC: begin
				raddr = dst_q[npcs_pkg::SLOT_W-1:npcs_pkg::LANE_W];
				st_d  = ST_DST;
			end
			ST_DST: begin
				st_d       = ST_SCAN;
				start_scan = 1'b1;
			end
			ST_SCAN: begin
				if (last_row) begin
					st_d = ST_DRAIN;
				end
			end
			ST_DRAIN: begin
				if (pipe_empty && (!m_tvalid_q || m_tready)) begin
					load_out = 1'b1;
					st_d     = ST_IDLE;
				end
			end
			default: begin
				st_d = ST_IDLE;
			end
		endcase
	end

	assign pal_we = cmd_pop && (cmd.op == npcs_pkg::OP_WRITE);

	// pick the pair entry out of the row just read; missing entries read black
	always_comb begin
		sel_idx      = (st_q == ST_SRC) ? src_q : dst_q;
		sel_lane     = sel_idx[npcs_pkg::LANE_W-1:0];
		sel_in_range = ({1'b0, sel_idx} < 9'(npcs_pkg::PAL_ENTRIES));
		if (sel_in_range && vld_s1[sel_lane]) begin
			sel_ent = npcs_pkg::colour_t'(data_s1[sel_lane]);
		end else begin
			sel_ent = '0;
		end
	end

	// target colour
	always_comb begin
		tgt_d = tgt_q;
		if (st_q == ST_IDLE) begin
			if (cmd.op == npcs_pkg::OP_WHITE) begin
				tgt_d = '{red: npcs_pkg::COMP_MAX, green: npcs_pkg::COMP_MAX,
					blue: npcs_pkg::COMP_MAX};
			end else begin
				tgt_d = cmd.colour;
			end
		end else if (op_q == npcs_pkg::OP_BRIGHT) begin
			tgt_d.red   = brighten(s_ent_q.red,   sel_ent.red);
			tgt_d.green = brighten(s_ent_q.green, sel_ent.green);
			tgt_d.blue  = brighten(s_ent_q.blue,  sel_ent.blue);
		end else begin
			tgt_d.red   = avg(s_ent_q.red,   sel_ent.red);
			tgt_d.green = avg(s_ent_q.green, sel_ent.green);
			tgt_d.blue  = avg(s_ent_q.blue,  sel_ent.blue);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q       <= ST_IDLE;
			row_q      <= '0;
			vld_q      <= '0;
			v_s1       <= 1'b0;
			v_s2       <= 1'b0;
			v_s3       <= 1'b0;
			best_en_q  <= 1'b0;
			m_tvalid_q <= 1'b0;
		end else begin
			st_q <= st_d;
			if (pal_we) begin
				vld_q[cmd.src_index[npcs_pkg::SLOT_W-1:0]] <= 1'b1;
			end
			if (start_scan) begin
				row_q <= '0;
			end else if (st_q == ST_SCAN) begin
				row_q <= row_q + 1'b1;
			end
			v_s1 <= (st_q == ST_SCAN);
			v_s2 <= v_s1;
			v_s3 <= v_s2;
			if (start_scan) begin
				best_en_q <= 1'b0;
			end else if (best_upd) begin
				best_en_q <= 1'b1;
			end
			if (load_out) begin
				m_tvalid_q <= 1'b1;
			end else if (m_tready) begin
				m_tvalid_q <= 1'b0;
			end
		end
	end

	// ---------------- palette memory ----------------
	always_ff @(posedge clk) begin
		for (int b = 0; b < L; b++) begin
			if (pal_we && (cmd.src_index[npcs_pkg::LANE_W-1:0] == npcs_pkg::LANE_W'(b))) begin
				bank_q[b][cmd.src_index[npcs_pkg::SLOT_W-1:npcs_pkg::LANE_W]] <=
					cmd.colour;
			end
			data_s1[b] <= bank_q[b][raddr];
		end
		vld_s1 <= vld_q[{raddr, npcs_pkg::LANE_W'(0)} +: L];
		row_s1 <= row_q;
	end

	// ---------------- scan pipeline ----------------
	always_comb begin
		logic [npcs_pkg::SLOT_W-1:0] idx;
		npcs_pkg::colour_t           e;
		for (int b = 0; b < L; b++) begin
			idx = {row_s1, npcs_pkg::LANE_W'(b)};
			e   = vld_s1[b] ? npcs_pkg::colour_t'(data_s1[b]) : '0;
			// index 0 is the transparent entry and never wins
			en_d[b]   = (idx != '0) &&
				({1'b0, idx} < (npcs_pkg::SLOT_W+1)'(npcs_pkg::PAL_ENTRIES));
			dist_d[b] = npcs_pkg::DIST_W'(sq_diff(e.red, tgt_q.red)) +
				npcs_pkg::DIST_W'(sq_diff(e.green, tgt_q.green)) +
				npcs_pkg::DIST_W'(sq_diff(e.blue, tgt_q.blue));
		end
	end

	always_comb begin
		for (int p = 0; p < 2; p++) begin
			pen_d[p] = en_s2[2*p] || en_s2[2*p+1];
			if (en_s2[2*p] && (!en_s2[2*p+1] || dist_s2[2*p] <= dist_s2[2*p+1])) begin
				pd_d[p]   = dist_s2[2*p];
				pidx_d[p] = {row_s2, npcs_pkg::LANE_W'(2*p)};
			end else begin
				pd_d[p]   = dist_s2[2*p+1];
				pidx_d[p] = {row_s2, npcs_pkg::LANE_W'(2*p+1)};
			end
		end
	end

	// final pick: lower index wins ties, rows arrive in ascending order
	always_comb begin
		fin_en = pen_s3[0] || pen_s3[1];
		if (pen_s3[0] && (!pen_s3[1] || pd_s3[0] <= pd_s3[1])) begin
			fin_d   = pd_s3[0];
			fin_idx = pidx_s3[0];
		end else begin
			fin_d   = pd_s3[1];
			fin_idx = pidx_s3[1];
		end
		best_upd = v_s3 && fin_en && (!best_en_q || fin_d < best_d_q);
	end

	always_ff @(posedge clk) begin
		if (cmd_pop) begin
			op_q  <= cmd.op;
			src_q <= cmd.src_index;
			dst_q <= cmd.dst_index;
		end
		if (st_q == ST_SRC) begin
			s_ent_q <= sel_ent;
		end
		if (cmd_pop || st_q == ST_DST) begin
			tgt_q <= tgt_d;
		end
		row_s2 <= row_s1;
		en_s2  <= en_d;
		for (int b = 0; b < L; b++) begin
			dist_s2[b] <= dist_d[b];
		end
		pen_s3 <= pen_d;
		for (int p = 0; p < 2; p++) begin
			pd_s3[p]   <= pd_d[p];
			pidx_s3[p] <= pidx_d[p];
		end
		if (best_upd) begin
			best_d_q    <= fin_d;
			lead_slot_q <= fin_idx;
		end
		if (load_out) begin
			m_tdata_q <= npcs_pkg::M_TDATA_W'(lead_slot_q);
		end
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = m_tdata_q;

	// ---------------- assertions ----------------
	a_no_transparent: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid_q |-> (m_tdata_q != '0))
		else $error("transparent entry returned as match");

	a_winner_found: assert property (@(posedge clk) disable iff (!arst_n)
		load_out |-> best_en_q)
		else $error("result loaded with no candidate seen");

	a_read_from_scan: assert property (@(posedge clk) disable iff (!arst_n)
		v_s1 |-> $past(st_q == ST_SCAN))
		else $error("scan row valid outside scan state");

endmodule

`default_nettype wire

// ----- design/nearest_palette_color_search_core.sv -----
// ---------------------------------------------------------------------------
// nearest_palette_color_search_core: nearest palette colour search
// Holds a palette and returns the index of the entry nearest a target colour.
// ---------------------------------------------------------------------------
// Usage
//   Slave stream s_*: one transfer per item, kind in s_tuser. A write item
//   stores one palette entry and yields no result; a query yields exactly
//   one result on the master stream m_* carrying the match index.
//   Items pass a two-deep command queue; s_tready drops only while it is full.
// Timing
//   A write is stored by the search engine as it leaves the queue. A direct
//   or white query leaves the queue and scans all ROWS rows; a pair query
//   first passes ST_SRC and ST_DST for the two palette reads of its source
//   and destination entries. The scan reads one row of four entries a cycle
//   and four distance lanes feed a registered compare tree.
// Reset
//   arst_n clears the queue, the state machine and all palette valid flags,
//   so every entry reads as black until written. No clearing pass is needed.
// Stall
//   A result waits in the output register while m_tready is low; the next
//   query runs its scan meanwhile and holds only before loading its result.
// ---------------------------------------------------------------------------
`default_nettype none

module nearest_palette_color_search_core (
	input  wire logic                           clk,
	input  wire logic                           arst_n,
	input  wire logic                           s_tvalid,
	output logic                                s_tready,
	// src_index[7:0], dst_index[15:8], red[23:16], green[31:24], blue[39:32]
	input  wire logic [npcs_pkg::S_TDATA_W-1:0] s_tdata,
	// kind[1:0]
	input  wire logic [npcs_pkg::S_TUSER_W-1:0] s_tuser,
	output logic                                m_tvalid,
	input  wire logic                           m_tready,
	// match_index[7:0]
	output logic [npcs_pkg::M_TDATA_W-1:0]      m_tdata
);

	logic           q_full;
	logic           q_push;
	npcs_pkg::cmd_t q_cmd;
	logic           q_pop;
	logic           head_valid;
	npcs_pkg::cmd_t head_cmd;

	npcs_front u_front (
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.q_full   (q_full),
		.q_push   (q_push),
		.q_cmd    (q_cmd)
	);

	npcs_cmd_fifo u_cmd_fifo (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (q_push),
		.push_cmd   (q_cmd),
		.full       (q_full),
		.pop        (q_pop),
		.head_valid (head_valid),
		.head_cmd   (head_cmd)
	);

	npcs_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd_valid (head_valid),
		.cmd       (head_cmd),
		.cmd_pop   (q_pop),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata)
	);

endmodule

`default_nettype wire
